FILE: hdl/r2cp_pkg.sv
`default_nettype none
package r2cp_pkg;

  localparam int REG_WIDTH = 40;
  localparam int COUNT_WIDTH_DEFAULT = 40;

  // Largest decimal value accepted on any number line.
  localparam logic [63:0] NUM_CAP = 64'd1000000000000;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic CFG_MAX_ARG_COUNT   = 1'b0;
  localparam logic CFG_MAX_BULK_LENGTH = 1'b1;

  typedef enum logic [3:0] {
    PH_STAR      = 4'd0,
    PH_CNT       = 4'd1,
    PH_CNT_LF    = 4'd2,
    PH_DOLLAR    = 4'd3,
    PH_LEN       = 4'd4,
    PH_LEN_MINUS = 4'd5,
    PH_LEN_LF    = 4'd6,
    PH_DATA      = 4'd7,
    PH_DATA_CR   = 4'd8,
    PH_DATA_LF   = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    KIND_FRAME   = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_ARG_END = 3'd2,
    KIND_CMD_END = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_IGNORED = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            data_out;
    logic [REG_WIDTH-1:0]  arg_index;
    logic [REG_WIDTH-1:0]  arg_total;
    logic [REG_WIDTH-1:0]  bytes_left;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/r2cp_cfg_regs.sv
`default_nettype none
module r2cp_cfg_regs #(
  parameter int COUNT_WIDTH = r2cp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_addr,
  input  wire logic [r2cp_pkg::REG_WIDTH-1:0] cfg_wdata,
  output logic      [COUNT_WIDTH-1:0]         arg_limit,
  output logic      [COUNT_WIDTH-1:0]         len_limit
);
  import r2cp_pkg::*;

  // Limits are kept already clamped to the decimal cap and the counter range.
  localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [63:0] CAP64   = (NUM_CAP < CNT_MAX) ? NUM_CAP : CNT_MAX;
  localparam logic [COUNT_WIDTH-1:0] CAP = CAP64[COUNT_WIDTH-1:0];

  logic [COUNT_WIDTH-1:0] wdata_clamped;

  always_comb begin
    if (64'(cfg_wdata) < CAP64) begin
      wdata_clamped = cfg_wdata[COUNT_WIDTH-1:0];
    end else begin
      wdata_clamped = CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_limit <= CAP;
      len_limit <= CAP;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_MAX_ARG_COUNT:   arg_limit <= wdata_clamped;
        CFG_MAX_BULK_LENGTH: len_limit <= wdata_clamped;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/r2cp_parse_core.sv
`default_nettype none
module r2cp_parse_core #(
  parameter int COUNT_WIDTH = r2cp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire logic [7:0]             byte_in,
  input  wire logic [COUNT_WIDTH-1:0] arg_limit,
  input  wire logic [COUNT_WIDTH-1:0] len_limit,
  output r2cp_pkg::result_t           result
);
  import r2cp_pkg::*;

  localparam int WW = COUNT_WIDTH + 4;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] number_value, number_value_next;
  logic                   minus_seen, minus_seen_next;
  logic                   digit_seen, digit_seen_next;
  logic [COUNT_WIDTH-1:0] args_total, args_total_next;
  logic [COUNT_WIDTH-1:0] args_done, args_done_next;
  logic [COUNT_WIDTH-1:0] payload_left, payload_left_next;
  logic                   error_latched, error_latched_next;

  logic                   is_digit;
  logic [WW-1:0]          num_wide;
  logic [WW-1:0]          value10;
  logic [COUNT_WIDTH-1:0] limit_sel;
  logic                   fits;
  logic [COUNT_WIDTH-1:0] left_dec;
  logic [COUNT_WIDTH-1:0] done_inc;
  logic                   bad;
  kind_t                  kind;
  logic [7:0]             dout;
  logic [COUNT_WIDTH-1:0] idx;

  assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign limit_sel = (phase == PH_CNT) ? arg_limit : len_limit;
  assign num_wide  = WW'(number_value);
  assign value10   = (num_wide << 3) + (num_wide << 1) + WW'(byte_in[3:0]);
  assign fits      = value10 <= WW'(limit_sel);
  assign left_dec  = (payload_left != '0) ? payload_left - COUNT_WIDTH'(1) : payload_left;
  assign done_inc  = args_done + COUNT_WIDTH'(1);

  always_comb begin
    phase_next         = phase;
    number_value_next  = number_value;
    minus_seen_next    = minus_seen;
    digit_seen_next    = digit_seen;
    args_total_next    = args_total;
    args_done_next     = args_done;
    payload_left_next  = payload_left;
    error_latched_next = error_latched;
    kind               = KIND_FRAME;
    dout               = 8'd0;
    idx                = args_done;
    bad                = 1'b0;

    if (error_latched) begin
      kind = KIND_IGNORED;
    end else begin
      unique case (phase)
        PH_STAR: begin
          if (byte_in == CH_STAR) begin
            args_total_next   = '0;
            args_done_next    = '0;
            payload_left_next = '0;
            idx               = '0;
            number_value_next = '0;
            minus_seen_next   = 1'b0;
            digit_seen_next   = 1'b0;
            phase_next        = PH_CNT;
          end else begin
            bad = 1'b1;
          end
        end
        PH_CNT: begin
          if (is_digit) begin
            number_value_next = value10[COUNT_WIDTH-1:0];
            digit_seen_next   = 1'b1;
            bad               = !fits;
          end else if (byte_in == CH_CR) begin
            if (!digit_seen || number_value == '0) begin
              bad = 1'b1;
            end else begin
              phase_next = PH_CNT_LF;
            end
          end else begin
            bad = 1'b1;
          end
        end
        PH_CNT_LF: begin
          if (byte_in == CH_LF) begin
            args_total_next = number_value;
            args_done_next  = '0;
            phase_next      = PH_DOLLAR;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DOLLAR: begin
          if (byte_in == CH_DOLLAR) begin
            number_value_next = '0;
            minus_seen_next   = 1'b0;
            digit_seen_next   = 1'b0;
            phase_next        = PH_LEN;
          end else begin
            bad = 1'b1;
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            number_value_next = value10[COUNT_WIDTH-1:0];
            digit_seen_next   = 1'b1;
            bad               = !fits || (minus_seen && value10 != '0);
          end else if (byte_in == CH_MINUS && !digit_seen && !minus_seen) begin
            minus_seen_next = 1'b1;
            phase_next      = PH_LEN_MINUS;
          end else if (byte_in == CH_CR && digit_seen) begin
            phase_next = PH_LEN_LF;
          end else begin
            bad = 1'b1;
          end
        end
        PH_LEN_MINUS: begin
          if (byte_in == CH_ZERO) begin
            digit_seen_next = 1'b1;
            phase_next      = PH_LEN;
          end else begin
            bad = 1'b1;
          end
        end
        PH_LEN_LF: begin
          if (byte_in == CH_LF) begin
            payload_left_next = number_value;
            phase_next        = (number_value == '0) ? PH_DATA_CR : PH_DATA;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DATA: begin
          kind              = KIND_DATA;
          dout              = byte_in;
          payload_left_next = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (byte_in == CH_CR) begin
            phase_next = PH_DATA_LF;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DATA_LF: begin
          if (byte_in == CH_LF) begin
            args_done_next = done_inc;
            if (done_inc >= args_total) begin
              kind       = KIND_CMD_END;
              phase_next = PH_STAR;
            end else begin
              kind       = KIND_ARG_END;
              phase_next = PH_DOLLAR;
            end
          end else begin
            bad = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase

      if (bad) begin
        kind               = KIND_ERROR;
        dout               = 8'd0;
        idx                = args_done;
        error_latched_next = 1'b1;
      end
    end

    result.kind       = kind;
    result.data_out   = dout;
    result.arg_index  = REG_WIDTH'(idx);
    result.arg_total  = REG_WIDTH'(args_total_next);
    result.bytes_left = (kind == KIND_DATA) ? REG_WIDTH'(payload_left_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_STAR;
      number_value  <= '0;
      minus_seen    <= 1'b0;
      digit_seen    <= 1'b0;
      args_total    <= '0;
      args_done     <= '0;
      payload_left  <= '0;
      error_latched <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      number_value  <= number_value_next;
      minus_seen    <= minus_seen_next;
      digit_seen    <= digit_seen_next;
      args_total    <= args_total_next;
      args_done     <= args_done_next;
      payload_left  <= payload_left_next;
      error_latched <= error_latched_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/resp2_command_parser_top.sv
`default_nettype none
// RESP2 command parser: takes a request stream one byte per transfer and
// returns exactly one result transfer per input byte, in order. A command is
// '*', a decimal argument count, CR LF, then that many bulk strings of the form
// '$', a decimal length, CR LF, payload, CR LF. Payload bytes come out with
// kind DATA, their argument index and the payload bytes still to come; the LF
// that closes an argument reports ARG_END, or CMD_END for the last argument;
// every other framing byte reports FRAME. The first byte that makes a valid
// command impossible (bad marker, bad digit, empty or zero count, negative
// length, value above 10^12, above the counter range or above the configured
// limit, missing CR or LF) reports ERROR; all later bytes report IGNORED until
// reset. Throughput is one byte per clock while out_ready stays high: the byte
// sits in an input register, one pass of the phase machine and its counters
// decides the result and next state, and the result goes to an output
// register. in_ready depends on out_ready through the output register's free
// slot. COUNT_WIDTH (8 to 40) sets the width of the count, length and index
// counters; values beyond its range are errors. Limit registers are written
// through cfg_wr_en/cfg_addr/cfg_wdata (index 0 max_arg_count, index 1
// max_bulk_length) while idle.
module resp2_command_parser_top #(
  parameter int COUNT_WIDTH = r2cp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // byte stream in
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     data_in,
  // results out
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [2:0]                     kind,
  output logic      [7:0]                     data_out,
  output logic      [r2cp_pkg::REG_WIDTH-1:0] arg_index,
  output logic      [r2cp_pkg::REG_WIDTH-1:0] arg_total,
  output logic      [r2cp_pkg::REG_WIDTH-1:0] bytes_left,
  // limit registers
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_addr,
  input  wire logic [r2cp_pkg::REG_WIDTH-1:0] cfg_wdata
);
  import r2cp_pkg::*;

  logic                   in_full;
  logic [7:0]             in_byte;
  logic                   advance;
  result_t                core_result;
  result_t                out_result;
  logic [COUNT_WIDTH-1:0] arg_limit;
  logic [COUNT_WIDTH-1:0] len_limit;

  // Move the held byte through the parser when the output slot is free or
  // is being emptied in this cycle.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register: load on an input transfer, drop once parsed.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_in;
    end
  end

  r2cp_cfg_regs #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .arg_limit (arg_limit),
    .len_limit (len_limit)
  );

  r2cp_parse_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .byte_in   (in_byte),
    .arg_limit (arg_limit),
    .len_limit (len_limit),
    .result    (core_result)
  );

  // Output register: hold the result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign kind       = out_result.kind;
  assign data_out   = out_result.data_out;
  assign arg_index  = out_result.arg_index;
  assign arg_total  = out_result.arg_total;
  assign bytes_left = out_result.bytes_left;

endmodule
`default_nettype wire

FILE: hdl/r2cp_checker.sv
`default_nettype none
module r2cp_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [2:0]                     kind,
  input wire logic [7:0]                     data_out,
  input wire logic [r2cp_pkg::REG_WIDTH-1:0] arg_index,
  input wire logic [r2cp_pkg::REG_WIDTH-1:0] arg_total,
  input wire logic [r2cp_pkg::REG_WIDTH-1:0] bytes_left
);
  import r2cp_pkg::*;

  logic [REG_WIDTH:0] index_plus_one;

  assign index_plus_one = {1'b0, arg_index} + (REG_WIDTH + 1)'(1);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_out)
      && $stable(arg_index) && $stable(bytes_left))
    else $error("result changed while stalled");

  // Only payload results carry a byte or a remaining count.
  a_non_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != 3'(KIND_DATA) |-> data_out == 8'd0 && bytes_left == '0)
    else $error("non-payload result carries payload fields");

  // Payload belongs to a declared argument.
  a_data_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == 3'(KIND_DATA) |-> arg_index < arg_total)
    else $error("payload index beyond argument count");

  // Command end closes exactly the last declared argument.
  a_cmd_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == 3'(KIND_CMD_END) |-> index_plus_one == {1'b0, arg_total})
    else $error("command end not on last argument");

endmodule

bind resp2_command_parser_top r2cp_checker u_r2cp_checker (.*);
`default_nettype wire

FILE: tb/tb_resp2_command_parser_top.sv
module tb_resp2_command_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import r2cp_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_LEN    = 400;
  localparam int DRAIN_LIMIT = 2000;

  localparam logic [REG_WIDTH-1:0] LIMIT_CAP    = NUM_CAP[REG_WIDTH-1:0];
  localparam logic [REG_WIDTH-1:0] REG_ALL_ONES = '1;
  // The counters are built at the default width, so their range also bounds values.
  localparam logic [63:0] COUNTER_MAX = (64'd1 << COUNT_WIDTH_DEFAULT) - 64'd1;

  // Ways to break the stream at the end of the run. The parser latches its
  // first error until reset and reset happens only once, so a run can end
  // with just one of these; the seed picks which.
  typedef enum int {
    TAIL_BAD_MARKER,
    TAIL_COUNT_OVER,
    TAIL_COUNT_MINUS,
    TAIL_LEN_NEG,
    TAIL_EMPTY_NUM,
    TAIL_ZERO_COUNT,
    TAIL_NO_LF,
    TAIL_BAD_DOLLAR,
    TAIL_NO_CR,
    TAIL_LEN_OVER,
    TAIL_BIG_COUNT,
    TAIL_BIG_LEN
  } tail_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic [7:0]           data_in   = 8'h00;
  logic                 out_ready = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_addr  = CFG_MAX_ARG_COUNT;
  logic [REG_WIDTH-1:0] cfg_wdata = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic [2:0]           kind;
  logic [7:0]           data_out;
  logic [REG_WIDTH-1:0] arg_index;
  logic [REG_WIDTH-1:0] arg_total;
  logic [REG_WIDTH-1:0] bytes_left;

  resp2_command_parser_top dut (.*);

  always #5 clk = ~clk;

  // Idle knobs, in percent: send_idle_pct for the sender task, stall_pct for the receiver process.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_request  = 1'b0;
  int byte_count    = 0;
  int mismatches    = 0;

  // Results the parser owes us, oldest first.
  result_t due_results[$];

  // ---------------------------------------------------------------------------
  // Parser mirror: phase machine, number accumulator, counters and the two
  // limit registers, all starting at their reset values.
  // ---------------------------------------------------------------------------
  phase_t               phase_q      = PH_STAR;
  logic [63:0]          num_acc      = '0;
  logic                 minus_flag   = 1'b0;
  logic                 digit_flag   = 1'b0;
  logic [REG_WIDTH-1:0] argc_total   = '0;
  logic [REG_WIDTH-1:0] argc_done    = '0;
  logic [REG_WIDTH-1:0] payload_cnt  = '0;
  logic                 err_latched  = 1'b0;
  logic [REG_WIDTH-1:0] count_limit  = LIMIT_CAP;
  logic [REG_WIDTH-1:0] length_limit = LIMIT_CAP;

  // Largest value a number line may reach under a given limit register.
  function automatic logic [63:0] value_cap(input logic [REG_WIDTH-1:0] limit_reg);
    logic [63:0] cap;
    cap = NUM_CAP;
    if (COUNTER_MAX < cap) cap = COUNTER_MAX;
    if (64'(limit_reg) < cap) cap = 64'(limit_reg);
    return cap;
  endfunction

  // Advance the mirror by one byte and return the result it must produce.
  function automatic result_t parse_next_byte(input logic [7:0] c);
    result_t     r;
    logic        bad;
    logic        is_digit;
    logic [63:0] digit;
    r           = '0;
    r.kind      = KIND_FRAME;
    r.arg_index = argc_done;
    bad         = 1'b0;
    is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
    digit       = 64'(c - CH_ZERO);
    if (err_latched) begin
      r.kind = KIND_IGNORED;
    end else begin
      case (phase_q)
        PH_STAR: begin
          if (c == CH_STAR) begin
            argc_total  = '0;
            argc_done   = '0;
            payload_cnt = '0;
            r.arg_index = '0;
            num_acc     = '0;
            minus_flag  = 1'b0;
            digit_flag  = 1'b0;
            phase_q     = PH_CNT;
          end else bad = 1'b1;
        end
        PH_CNT: begin
          // Any minus is fatal here: the count could never reach one.
          if (is_digit) begin
            num_acc    = num_acc * 64'd10 + digit;
            digit_flag = 1'b1;
            bad        = num_acc > value_cap(count_limit);
          end else if (c == CH_CR && digit_flag && num_acc != 0) begin
            phase_q = PH_CNT_LF;
          end else bad = 1'b1;
        end
        PH_CNT_LF: begin
          if (c == CH_LF) begin
            argc_total = num_acc[REG_WIDTH-1:0];
            argc_done  = '0;
            phase_q    = PH_DOLLAR;
          end else bad = 1'b1;
        end
        PH_DOLLAR: begin
          if (c == CH_DOLLAR) begin
            num_acc    = '0;
            minus_flag = 1'b0;
            digit_flag = 1'b0;
            phase_q    = PH_LEN;
          end else bad = 1'b1;
        end
        PH_LEN: begin
          // After a minus only zeros may follow; the first nonzero digit fails.
          if (is_digit) begin
            num_acc    = num_acc * 64'd10 + digit;
            digit_flag = 1'b1;
            bad        = (num_acc > value_cap(length_limit)) || (minus_flag && num_acc != 0);
          end else if (c == CH_MINUS && !digit_flag && !minus_flag) begin
            minus_flag = 1'b1;
            phase_q    = PH_LEN_MINUS;
          end else if (c == CH_CR && digit_flag) begin
            phase_q = PH_LEN_LF;
          end else bad = 1'b1;
        end
        PH_LEN_MINUS: begin
          if (c == CH_ZERO) begin
            digit_flag = 1'b1;
            phase_q    = PH_LEN;
          end else bad = 1'b1;
        end
        PH_LEN_LF: begin
          if (c == CH_LF) begin
            payload_cnt = num_acc[REG_WIDTH-1:0];
            phase_q     = (payload_cnt == 0) ? PH_DATA_CR : PH_DATA;
          end else bad = 1'b1;
        end
        PH_DATA: begin
          r.kind     = KIND_DATA;
          r.data_out = c;
          if (payload_cnt != 0) payload_cnt--;
          if (payload_cnt == 0) phase_q = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (c == CH_CR) phase_q = PH_DATA_LF;
          else bad = 1'b1;
        end
        PH_DATA_LF: begin
          if (c == CH_LF) begin
            argc_done = argc_done + REG_WIDTH'(1);
            if (argc_done >= argc_total) begin
              r.kind  = KIND_CMD_END;
              phase_q = PH_STAR;
            end else begin
              r.kind  = KIND_ARG_END;
              phase_q = PH_DOLLAR;
            end
          end else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        r.kind      = KIND_ERROR;
        r.data_out  = '0;
        r.arg_index = argc_done;
        err_latched = 1'b1;
      end
    end
    r.arg_total  = argc_total;
    r.bytes_left = (r.kind == KIND_DATA) ? payload_cnt : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Offer one byte, holding valid and data until the transfer, then record
  // what the parser has to answer.
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_results.insert(due_results.size(), parse_next_byte(b));
    byte_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Any byte but the one the parser is waiting for.
  function automatic logic [7:0] other_byte(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == avoid) b = b ^ 8'h01;
    return b;
  endfunction

  // One bulk string; length lines get leading zeros now and then, and a zero
  // length is sometimes spelled with a minus.
  task automatic send_bulk(input longint unsigned len);
    string txt;
    txt = $sformatf("%0d", len);
    if ($urandom_range(3) == 0) txt = {"0", txt};
    if (len == 0 && $urandom_range(1) == 1) txt = {"-", txt};
    send_text({"$", txt, "\r\n"});
    repeat (len) send_byte(8'($urandom_range(255)));
    send_text("\r\n");
  endtask

  // Full command with nargs arguments; about a quarter of them sit exactly at len_max.
  task automatic send_command(input longint unsigned nargs, input int len_max);
    string txt;
    txt = $sformatf("%0d", nargs);
    if ($urandom_range(4) == 0) txt = {"00", txt};
    send_text({"*", txt, "\r\n"});
    repeat (nargs) begin
      send_bulk(($urandom_range(3) == 0) ? len_max : $urandom_range(len_max));
    end
  endtask

  // Well-formed command that fits the current limits, mostly short.
  task automatic send_random_command();
    int nargs;
    int len_max;
    nargs = $urandom_range(1, (count_limit < 5) ? int'(count_limit) : 5);
    if (length_limit < 12) len_max = int'(length_limit);
    else if (length_limit >= 40 && $urandom_range(9) == 0) len_max = 40;
    else len_max = 12;
    send_command(nargs, len_max);
  endtask

  // Write both limit registers once the parser has drained. Never call this
  // twice without sending bytes in between.
  task automatic set_limits(input logic [REG_WIDTH-1:0] count_lim,
                            input logic [REG_WIDTH-1:0] len_lim);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_MAX_ARG_COUNT;
    cfg_wdata <= count_lim;
    @(posedge clk);
    count_limit = count_lim;
    cfg_addr  <= CFG_MAX_BULK_LENGTH;
    cfg_wdata <= len_lim;
    @(posedge clk);
    length_limit = len_lim;
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Leading zeros on the count, "-0" and a padded length, a zero-length
  // argument, payload bytes at both ends of the range, argument and command end.
  task automatic test_directed();
    send_text("*02\r\n$-0\r\n\r\n$002\r\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\r\n");
  endtask

  // Limit registers at their extremes and at small values hit exactly.
  task automatic test_limits();
    set_limits(40'd1, 40'd0);
    repeat (6) send_random_command();
    set_limits(40'($urandom_range(2, 5)), 40'($urandom_range(1, 9)));
    repeat (3) send_command(count_limit, int'(length_limit));
    set_limits(REG_ALL_ONES, REG_ALL_ONES);
    repeat (2) send_random_command();
    set_limits(LIMIT_CAP, LIMIT_CAP);
    repeat (2) send_random_command();
  endtask

  task automatic run_phase(input int send_pct, input int stall, input int n_bytes);
    int start;
    send_idle_pct = send_pct;
    stall_pct     = stall;
    set_limits(($urandom_range(3) == 0) ? 40'($urandom_range(1, 4)) : LIMIT_CAP,
               ($urandom_range(3) == 0) ? 40'($urandom_range(0, 6)) : LIMIT_CAP);
    start = byte_count;
    while (byte_count - start < n_bytes) send_random_command();
  endtask

  // Random commands under each idle pattern, fresh limits per phase.
  task automatic test_random_traffic();
    run_phase(0, 0, 330);
    run_phase(50, 0, 330);
    run_phase(0, 50, 330);
    run_phase(12, 12, 330);
  endtask

  // Receiver goes quiet for a long stretch while bytes keep coming, so the
  // output register fills and in_ready must drop.
  task automatic test_backpressure();
    int start;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b1;
    start = byte_count;
    while (byte_count - start < 100) send_random_command();
  endtask

  // Finish with one broken sequence, then noise that must come back as ignored,
  // or with a huge payload that never closes, which the noise then feeds.
  task automatic test_error_tail();
    tail_t tail;
    tail = tail_t'($urandom_range(int'(TAIL_BIG_LEN)));
    send_idle_pct = 12;
    stall_pct     = 12;
    if (tail == TAIL_BIG_COUNT || tail == TAIL_BIG_LEN) begin
      set_limits(LIMIT_CAP, LIMIT_CAP);
    end else begin
      set_limits(($urandom_range(1) == 0) ? 40'($urandom_range(1, 4)) : LIMIT_CAP,
                 ($urandom_range(1) == 0) ? 40'($urandom_range(0, 6)) : LIMIT_CAP);
    end
    send_random_command();
    case (tail)
      TAIL_BAD_MARKER:  send_byte(other_byte(CH_STAR));
      TAIL_COUNT_OVER:  send_text($sformatf("*%0d", 64'(count_limit) + 64'd1));
      TAIL_COUNT_MINUS: send_text("*-1");
      TAIL_LEN_NEG:     send_text(($urandom_range(1) == 0) ? "*1\r\n$-5" : "*1\r\n$-007");
      TAIL_EMPTY_NUM:   send_text(($urandom_range(1) == 0) ? "*\r" : "*1\r\n$\r");
      TAIL_ZERO_COUNT:  send_text("*000\r");
      TAIL_NO_LF: begin
        case ($urandom_range(2))
          0:       send_text("*2\r");
          1:       send_text("*1\r\n$1\r");
          default: send_text("*1\r\n$1\r\nx\r");
        endcase
        send_byte(other_byte(CH_LF));
      end
      TAIL_BAD_DOLLAR: begin
        send_text("*1\r\n");
        send_byte(other_byte(CH_DOLLAR));
      end
      TAIL_NO_CR: begin
        send_text("*1\r\n$2\r\nab");
        send_byte(other_byte(CH_CR));
      end
      TAIL_LEN_OVER:    send_text($sformatf("*1\r\n$%0d", 64'(length_limit) + 64'd1));
      TAIL_BIG_COUNT: begin
        // Largest legal count: two arguments, then the next marker is wrong.
        send_text("*1000000000000\r\n");
        repeat (2) send_bulk($urandom_range(12));
        send_byte(other_byte(CH_DOLLAR));
      end
      default: send_text("*1\r\n$1000000000000\r\n");
    endcase
    repeat (24) send_byte(8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off that it counts itself.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_cycles;
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_cycles  = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every transfer out is matched against the oldest result due.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [REG_WIDTH-1:0] want,
                             input logic [REG_WIDTH-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none due, kind %0d data %0d", $time, kind, data_out);
      end else begin
        want = due_results.pop_front();
        check_field("kind", REG_WIDTH'(want.kind), REG_WIDTH'(kind));
        check_field("data_out", REG_WIDTH'(want.data_out), REG_WIDTH'(data_out));
        check_field("arg_index", want.arg_index, arg_index);
        check_field("arg_total", want.arg_total, arg_total);
        check_field("bytes_left", want.bytes_left, bytes_left);
      end
    end
  end

  // Watchdog: end the run when neither channel has moved for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("FAIL resp2_command_parser_top");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    int drain;
    drain = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_limits();
    test_random_traffic();
    test_backpressure();
    test_error_tail();

    // Drop valid, open the receiver and let the last results drain.
    in_valid <= 1'b0;
    stall_pct = 0;
    while (due_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (due_results.size() != 0) begin
      mismatches += due_results.size();
      $display("%0t: %0d results never arrived", $time, due_results.size());
    end
    // Catch any stray result the two-stage pipe might still push out.
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS resp2_command_parser_top");
    end else begin
      $display("FAIL resp2_command_parser_top");
    end
    $finish;
  end

endmodule
